// ===== design/iaf_pkg.sv =====
// Shared types, constants and character helpers for the integer to ASCII formatter.
// No dependencies; imported by every module of the block.
package iaf_pkg;

  localparam int VALUE_WIDTH           = 64;
  localparam int DEFAULT_POINTER_WIDTH = 64;
  localparam int DEC_BITS              = 32;  // binary bits fed to the BCD converter
  localparam int DEC_DIGITS            = 10;  // decimal digits of a 32-bit magnitude

  // Format selector codes on the operation port
  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEXL = 3'd2;
  localparam logic [2:0] OP_HEXU = 3'd3;
  localparam logic [2:0] OP_PTR  = 3'd4;

  // ASCII codes used outside the digit tables
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;

  typedef enum logic [1:0] {
    FMT_DEC,
    FMT_HEX,
    FMT_PTR
  } fmt_t;

  // One classified word, as it travels from front to back
  typedef struct packed {
    fmt_t                   fmt;
    logic                   upper;
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } desc_t;

  // Map one digit to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UP_A : CHAR_LOW_A;
    if (d < 4'd10) begin
      digit_char = CHAR_ZERO + {4'b0, d};
    end else begin
      digit_char = base + {4'b0, d} - 8'd10;
    end
  endfunction

endpackage

// ===== design/iaf_front.sv =====
// Front end: accepts a word, classifies the format and forms the magnitude.
// Depends on iaf_pkg.
module iaf_front #(
  parameter int POINTER_WIDTH = iaf_pkg::DEFAULT_POINTER_WIDTH
) (
  input  logic                             start,
  input  logic                             full,
  input  logic [iaf_pkg::VALUE_WIDTH-1:0]  value,
  input  logic [2:0]                       operation,
  output logic                             push,
  output iaf_pkg::desc_t                   desc
);
  import iaf_pkg::*;

  localparam logic [VALUE_WIDTH-1:0] PTR_MASK =
    {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - POINTER_WIDTH);

  logic                 known;
  logic [DEC_BITS-1:0]  low;

  assign low = value[DEC_BITS-1:0];

  // Classify the selector; drop unused codes
  always_comb begin
    known      = 1'b1;
    desc.fmt   = FMT_DEC;
    desc.upper = 1'b0;
    desc.neg   = 1'b0;
    desc.mag   = {{(VALUE_WIDTH-DEC_BITS){1'b0}}, low};
    unique case (operation)
      OP_SDEC: begin
        desc.neg = low[DEC_BITS-1];
        if (low[DEC_BITS-1]) begin
          desc.mag = {{(VALUE_WIDTH-DEC_BITS){1'b0}}, DEC_BITS'(-low)};
        end
      end
      OP_UDEC: begin
        desc.fmt = FMT_DEC;
      end
      OP_HEXL: begin
        desc.fmt = FMT_HEX;
      end
      OP_HEXU: begin
        desc.fmt   = FMT_HEX;
        desc.upper = 1'b1;
      end
      OP_PTR: begin
        desc.fmt = FMT_PTR;
        desc.mag = value & PTR_MASK;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push = start && !full && known;

endmodule

// ===== design/iaf_queue.sv =====
// Two-entry word queue between the front end and the character sequencer.
// Depends on iaf_pkg for the descriptor type.
module iaf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  iaf_pkg::desc_t  push_desc,
  input  logic            pop,
  output iaf_pkg::desc_t  head,
  output logic            empty,
  output logic            full
);
  import iaf_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  desc_t              entry [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign head  = entry[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_desc;
    end
  end

endmodule

// ===== design/iaf_back.sv =====
// Back end: converts a queued word to digits and emits at most one character per cycle.
// Depends on iaf_pkg.
module iaf_back #(
  parameter int POINTER_WIDTH = iaf_pkg::DEFAULT_POINTER_WIDTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  iaf_pkg::desc_t  head,
  output logic            pop,
  output logic            strobe,
  output logic [7:0]      character,
  output logic            last,
  output logic [4:0]      emitted_count
);
  import iaf_pkg::*;

  localparam int PTR_NIBBLES = (POINTER_WIDTH + 3) / 4;
  localparam int PTR_SHIFT   = VALUE_WIDTH - 4 * PTR_NIBBLES;
  localparam int BCD_W       = 4 * DEC_DIGITS;
  localparam int ITER_W      = $clog2(DEC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_PFX0,
    ST_PFX1,
    ST_DIGITS
  } state_t;

  state_t                  state;
  logic [DEC_BITS-1:0]     bin;
  logic [BCD_W-1:0]        bcd;
  logic [BCD_W-1:0]        bcd_adj;
  logic [BCD_W-1:0]        bcd_next;
  logic [ITER_W-1:0]       iter;
  logic [VALUE_WIDTH-1:0]  digs;
  logic [4:0]              rem;
  logic [4:0]              cnt;
  logic                    started;
  logic                    upper;
  logic                    neg;
  logic [3:0]              cur;

  assign pop = (state == ST_IDLE) && !empty;
  assign cur = digs[VALUE_WIDTH-1 -: 4];

  // Add three to each BCD digit of five or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
    bcd_next = {bcd_adj[BCD_W-2:0], bin[DEC_BITS-1]};
  end

  // Sequence conversion and character output
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      strobe  <= 1'b0;
      started <= 1'b0;
      cnt     <= '0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            upper   <= head.upper;
            neg     <= head.neg;
            cnt     <= '0;
            started <= 1'b0;
            unique case (head.fmt)
              FMT_DEC: begin
                bin   <= head.mag[DEC_BITS-1:0];
                bcd   <= '0;
                iter  <= '0;
                state <= ST_CONV;
              end
              FMT_HEX: begin
                digs  <= {head.mag[DEC_BITS-1:0], {(VALUE_WIDTH-DEC_BITS){1'b0}}};
                rem   <= 5'(DEC_BITS / 4);
                state <= ST_DIGITS;
              end
              FMT_PTR: begin
                digs  <= head.mag << PTR_SHIFT;
                rem   <= 5'(PTR_NIBBLES);
                state <= ST_PFX0;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CONV: begin
          bcd  <= bcd_next;
          bin  <= bin << 1;
          iter <= iter + 1'b1;
          if (iter == ITER_W'(DEC_BITS - 1)) begin
            digs  <= {bcd_next, {(VALUE_WIDTH-BCD_W){1'b0}}};
            rem   <= 5'(DEC_DIGITS);
            state <= neg ? ST_SIGN : ST_DIGITS;
          end
        end
        ST_SIGN: begin
          strobe        <= 1'b1;
          character     <= CHAR_MINUS;
          last          <= 1'b0;
          emitted_count <= cnt + 1'b1;
          cnt           <= cnt + 1'b1;
          state         <= ST_DIGITS;
        end
        ST_PFX0: begin
          strobe        <= 1'b1;
          character     <= CHAR_ZERO;
          last          <= 1'b0;
          emitted_count <= cnt + 1'b1;
          cnt           <= cnt + 1'b1;
          state         <= ST_PFX1;
        end
        ST_PFX1: begin
          strobe        <= 1'b1;
          character     <= CHAR_X;
          last          <= 1'b0;
          emitted_count <= cnt + 1'b1;
          cnt           <= cnt + 1'b1;
          state         <= ST_DIGITS;
        end
        ST_DIGITS: begin
          digs <= {digs[VALUE_WIDTH-5:0], 4'b0};
          rem  <= rem - 1'b1;
          // Skip leading zeros, but always keep the final digit
          if (started || cur != 4'd0 || rem == 5'd1) begin
            started       <= 1'b1;
            strobe        <= 1'b1;
            character     <= digit_char(cur, upper);
            last          <= (rem == 5'd1);
            emitted_count <= cnt + 1'b1;
            cnt           <= cnt + 1'b1;
          end
          if (rem == 5'd1) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: front end, word queue, back end.
// Depends on iaf_pkg, iaf_front, iaf_queue and iaf_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   input    | start, busy         | value[63:0], operation[2:0]
//   result   | strobe (one cycle)  | character[7:0], last, emitted_count[4:0]
//
// A word is taken when start is high and busy is low; busy is high only while
// the two-entry queue is full. Hex words step through one nibble slot per
// cycle (8 slots, or the two prefix characters and ceil(POINTER_WIDTH/4) slots
// for pointers), leading zeros producing no result. Decimal words first run a
// bit-serial BCD conversion of 32 bits, then a minus sign if negative, then
// their 10 digit slots. Unused selector codes are dropped at the front. Reset
// is synchronous and empties the queue; the receiver cannot stall, so each
// result is shown for exactly one cycle.
module integer_to_ascii_formatter #(
  parameter int POINTER_WIDTH = iaf_pkg::DEFAULT_POINTER_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [iaf_pkg::VALUE_WIDTH-1:0] value,
  input  logic [2:0]                      operation,
  output logic                            strobe,
  output logic [7:0]                      character,
  output logic                            last,
  output logic [4:0]                      emitted_count
);
  import iaf_pkg::*;

  logic   push;
  logic   pop;
  logic   empty;
  logic   full;
  desc_t  push_desc;
  desc_t  head;

  assign busy = full;

  iaf_front #(
    .POINTER_WIDTH(POINTER_WIDTH)
  ) u_front (
    .start     (start),
    .full      (full),
    .value     (value),
    .operation (operation),
    .push      (push),
    .desc      (push_desc)
  );

  iaf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  iaf_back #(
    .POINTER_WIDTH(POINTER_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .strobe        (strobe),
    .character     (character),
    .last          (last),
    .emitted_count (emitted_count)
  );

endmodule

// ===== test/tb_integer_to_ascii_formatter.sv =====
// Testbench for integer_to_ascii_formatter: drives value/format words, predicts each text
// character by character and checks every strobed result. Depends on iaf_pkg and the RTL.
module tb_integer_to_ascii_formatter;
  import iaf_pkg::*;

  localparam int PTR_W       = 64;
  localparam int SETTLE_CYC  = 100;  // hold-off after the last result
  localparam int LIMIT_CYC   = 400000;

  // One word queued for the sender, or a marker that makes it wait for the block to drain
  typedef struct {
    logic [63:0] val;
    logic [2:0]  op;
    bit          drain;
    int          idle_pct;
  } send_word_t;

  // One expected character of the formatted text
  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
    logic [4:0] cnt;
  } text_char_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] value;
  logic [2:0]  operation;
  logic        strobe;
  logic [7:0]  character;
  logic        last;
  logic [4:0]  emitted_count;

  send_word_t words_to_send[$];
  text_char_t chars_due[$];
  int         error_count;
  int         drain_wait;

  integer_to_ascii_formatter #(.POINTER_WIDTH(PTR_W)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .value(value),
    .operation(operation),
    .strobe(strobe),
    .character(character),
    .last(last),
    .emitted_count(emitted_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Build the text for one word and queue its characters
  function automatic void queue_formatted_text(input logic [63:0] v, input logic [2:0] op);
    string       digit_set;
    byte         text[$];
    byte         digs[$];
    logic [63:0] mag;
    logic [63:0] base;
    text_char_t  rec;
    digit_set = "0123456789abcdef";
    base = 64'd16;
    mag = {32'd0, v[31:0]};
    case (op)
      OP_SDEC: begin
        base = 64'd10;
        if (v[31]) begin
          mag = 64'h1_0000_0000 - {32'd0, v[31:0]};
          text.push_back(CHAR_MINUS);
        end
      end
      OP_UDEC: base = 64'd10;
      OP_HEXL: ;
      OP_HEXU: digit_set = "0123456789ABCDEF";
      OP_PTR: begin
        mag = v & ({64{1'b1}} >> (64 - PTR_W));
        text.push_back(CHAR_ZERO);
        text.push_back(CHAR_X);
      end
      default: return;  // unused selector: no text
    endcase
    // peel digits off the bottom, at least one
    do begin
      digs.push_front(digit_set[int'(mag % base)]);
      mag = mag / base;
    end while (mag != 0);
    foreach (digs[i]) text.push_back(digs[i]);
    foreach (text[i]) begin
      rec.ch  = text[i];
      rec.lst = (i == text.size() - 1);
      rec.cnt = 5'(i + 1);
      chars_due.push_back(rec);
    end
  endfunction

  // Driver: present queued words, hold each until taken, stall for drain markers
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      drain_wait <= 0;
    end else begin
      if (start && !busy) queue_formatted_text(value, operation);
      if (!(start && busy)) begin
        if (words_to_send.size() > 0 && words_to_send[0].drain) begin
          start <= 1'b0;
          if (chars_due.size() == 0 && !(start && !busy)) begin
            if (drain_wait >= SETTLE_CYC) begin
              void'(words_to_send.pop_front());
              drain_wait <= 0;
            end else begin
              drain_wait <= drain_wait + 1;
            end
          end
        end else if (words_to_send.size() > 0 &&
                     $urandom_range(0, 99) >= words_to_send[0].idle_pct) begin
          send_word_t w;
          w = words_to_send.pop_front();
          value     <= w.val;
          operation <= w.op;
          start     <= 1'b1;
        end else begin
          start     <= 1'b0;
          value     <= {$urandom, $urandom};
          operation <= 3'($urandom);
        end
      end
    end
  end

  // Monitor: check every strobed character against the oldest expectation
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (chars_due.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", character));
      end else begin
        text_char_t exp_c;
        exp_c = chars_due.pop_front();
        if (character !== exp_c.ch)
          report_mismatch($sformatf("character 0x%02h, want 0x%02h", character, exp_c.ch));
        if (last !== exp_c.lst)
          report_mismatch($sformatf("last %b, want %b", last, exp_c.lst));
        if (emitted_count !== exp_c.cnt)
          report_mismatch($sformatf("emitted_count %0d, want %0d", emitted_count, exp_c.cnt));
      end
    end
  end

  task automatic add_word(input logic [63:0] v, input logic [2:0] op, input int idle);
    send_word_t w;
    w.val = v;
    w.op = op;
    w.drain = 1'b0;
    w.idle_pct = idle;
    words_to_send.push_back(w);
  endtask

  task automatic add_drain();
    send_word_t w;
    w.val = '0;
    w.op = OP_SDEC;
    w.drain = 1'b1;
    w.idle_pct = 0;
    words_to_send.push_back(w);
  endtask

  // Pick a value that lands on magnitudes and boundaries of interest
  function automatic logic [63:0] rand_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: return r;
      1: return 64'($urandom_range(0, 20));
      2: return r >> $urandom_range(0, 63);
      3: begin
        case ($urandom_range(0, 3))
          0: r[31:0] = 32'h8000_0000;
          1: r[31:0] = 32'h7FFF_FFFF;
          2: r[31:0] = 32'hFFFF_FFFF;
          default: r[31:0] = 32'd0;
        endcase
        return r;
      end
      4: return {r[63:32], r[31:0] >> $urandom_range(0, 31)};
      default: return {32'd0, r[31:0]};
    endcase
  endfunction

  // Stimulus and end of run
  initial begin
    int idle;
    logic [2:0] op;
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    operation = OP_SDEC;
    error_count = 0;
    drain_wait = 0;

    // directed: zeros, extremes, each format, ignored selectors, high bits
    add_word(64'd0, OP_SDEC, 0);
    add_word(64'd0, OP_UDEC, 0);
    add_word(64'd0, OP_HEXL, 0);
    add_word(64'd0, OP_HEXU, 0);
    add_word(64'd0, OP_PTR, 0);
    add_word(64'h0000_0000_8000_0000, OP_SDEC, 0);
    add_word(64'h0000_0000_7FFF_FFFF, OP_SDEC, 0);
    add_word(64'h0000_0000_FFFF_FFFF, OP_SDEC, 0);
    add_word(64'h0000_0000_FFFF_FFFF, OP_UDEC, 0);
    add_word(64'd9, OP_UDEC, 0);
    add_word(64'd10, OP_SDEC, 0);
    add_word(64'h0000_0000_DEAD_BEEF, OP_HEXL, 0);
    add_word(64'h0000_0000_ABCD_EF01, OP_HEXU, 0);
    add_word(64'hFFFF_FFFF_FFFF_FFFF, OP_PTR, 0);
    add_word(64'd1, OP_PTR, 0);
    add_word(64'h1000_0000_0000_0000, OP_PTR, 0);
    add_word(64'hFFFF_FFFF_0000_0000, OP_SDEC, 0);
    add_word(64'hFFFF_FFFF_0000_000A, OP_HEXU, 0);
    add_word(64'h1234_5678_9ABC_DEF0, 3'd5, 0);
    add_word(64'h1234_5678_9ABC_DEF0, 3'd6, 0);
    add_word(64'h1234_5678_9ABC_DEF0, 3'd7, 0);
    add_word(64'hFFFF_FFFF_FFFF_FFFF, OP_HEXL, 0);
    add_drain();

    // random: sender idles 14%, then 66%, then never
    for (int phase = 0; phase < 3; phase++) begin
      idle = (phase == 0) ? 14 : (phase == 1) ? 66 : 0;
      for (int n = 0; n < 116; n++) begin
        op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
        add_word(rand_value(), op, idle);
        if (n == 60) add_drain();
      end
      add_drain();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (words_to_send.size() != 0 || start) @(posedge clk);
    while (chars_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_integer_to_ascii_formatter: done, clean");
    end else begin
      $display("tb_integer_to_ascii_formatter: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYC * 4);
    $display("tb_integer_to_ascii_formatter: done, errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/iaf_pkg.sv
design/iaf_front.sv
design/iaf_queue.sv
design/iaf_back.sv
design/integer_to_ascii_formatter.sv
test/tb_integer_to_ascii_formatter.sv
